FILE: sv/artdmx_packet_framer_core_defines.svh
// assertion macros for the artdmx packet framer
`ifndef ARTDMX_PACKET_FRAMER_CORE_DEFINES_SVH
`define ARTDMX_PACKET_FRAMER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked outside reset
`define ADF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("adf check failed");
// next-cycle implication, checked outside reset
`define ADF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("adf check failed");
`else
`define ADF_ASSERT_IMPL(label, ante, cons)
`define ADF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: sv/adf_pkg.sv
`default_nettype none
package adf_pkg;

    // field widths
    localparam int DATA_W       = 8;
    localparam int LEN_W        = 10;
    localparam int MAX_CHANNELS = 512;

    // header layout
    localparam int HDR_BYTES = 18;
    localparam int POS_W     = 5;

    // queue sizing
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    // header byte positions
    localparam logic [POS_W-1:0] POS_ID_A     = 5'd0;
    localparam logic [POS_W-1:0] POS_ID_R     = 5'd1;
    localparam logic [POS_W-1:0] POS_ID_T0    = 5'd2;
    localparam logic [POS_W-1:0] POS_ID_DASH  = 5'd3;
    localparam logic [POS_W-1:0] POS_ID_N     = 5'd4;
    localparam logic [POS_W-1:0] POS_ID_E     = 5'd5;
    localparam logic [POS_W-1:0] POS_ID_T1    = 5'd6;
    localparam logic [POS_W-1:0] POS_OP_HI    = 5'd9;
    localparam logic [POS_W-1:0] POS_VER_LO   = 5'd11;
    localparam logic [POS_W-1:0] POS_SEQ      = 5'd12;
    localparam logic [POS_W-1:0] POS_LEN_HI   = 5'd16;
    localparam logic [POS_W-1:0] POS_LEN_LO   = 5'd17;
    localparam logic [POS_W-1:0] POS_LAST_HDR = 5'd17;

    // header constants
    localparam logic [15:0]       OPCODE_OUTPUT = 16'h5000;
    localparam logic [DATA_W-1:0] PROTO_VER_LO  = 8'd14;
    localparam logic [LEN_W-1:0]  LEN_RESET     = 10'd512;

    // one classified channel byte
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              hdr;
        logic              last;
        logic [7:0]        seq;
        logic [LEN_W-1:0]  len;
    } t_item;

    // front to queue request
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_push;

    // queue head toward the back
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    // header byte at a position
    function automatic logic [DATA_W-1:0] hdr_byte(
        input logic [POS_W-1:0]  pos,
        input logic [7:0]        seq,
        input logic [LEN_W-1:0]  len
    );
        logic [DATA_W-1:0] b;
        b = '0;
        case (pos)
            POS_ID_A:    b = 8'h41;
            POS_ID_R:    b = 8'h72;
            POS_ID_T0:   b = 8'h74;
            POS_ID_DASH: b = 8'h2d;
            POS_ID_N:    b = 8'h4e;
            POS_ID_E:    b = 8'h65;
            POS_ID_T1:   b = 8'h74;
            POS_OP_HI:   b = OPCODE_OUTPUT[15:8];
            POS_VER_LO:  b = PROTO_VER_LO;
            POS_SEQ:     b = seq;
            POS_LEN_HI:  b = {{(2*DATA_W-LEN_W){1'b0}}, len[LEN_W-1:DATA_W]};
            POS_LEN_LO:  b = len[DATA_W-1:0];
            default:     b = '0;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

FILE: sv/adf_front.sv
`default_nettype none
module adf_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [adf_pkg::DATA_W-1:0]    i_channel_byte,
    input  wire logic [adf_pkg::LEN_W-1:0]     i_frame_length,
    input  wire logic                          i_full,
    output logic                               o_stall,
    output adf_pkg::t_push                     o_push
);

    logic [adf_pkg::LEN_W-1:0] r_index;
    logic [adf_pkg::LEN_W-1:0] n_index;
    logic [7:0]                r_seq;
    logic [7:0]                n_seq;
    logic [adf_pkg::LEN_W-1:0] eff_len;
    logic [adf_pkg::LEN_W:0]   index_inc;
    logic                      accept;
    logic                      starts;
    logic                      last;
    logic [7:0]                seq_inc;

    // effective length, clamped to 1..max
    always_comb begin
        eff_len = i_frame_length;
        if (i_frame_length == '0) begin
            eff_len = adf_pkg::LEN_W'(1);
        end else if (i_frame_length > adf_pkg::LEN_W'(adf_pkg::MAX_CHANNELS)) begin
            eff_len = adf_pkg::LEN_W'(adf_pkg::MAX_CHANNELS);
        end
    end

    // classify the incoming byte
    assign o_stall   = i_full;
    assign accept    = i_valid && !i_full;
    assign starts    = (r_index == '0);
    assign index_inc = {1'b0, r_index} + (adf_pkg::LEN_W+1)'(1);
    assign last      = (index_inc >= {1'b0, eff_len});
    assign seq_inc   = r_seq + 8'd1;

    // next position and sequence
    always_comb begin
        n_index = r_index;
        n_seq   = r_seq;
        if (accept) begin
            n_index = last ? '0 : index_inc[adf_pkg::LEN_W-1:0];
            if (starts) begin
                n_seq = (seq_inc == 8'd0) ? 8'd1 : seq_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_seq   <= '0;
        end else begin
            r_index <= n_index;
            r_seq   <= n_seq;
        end
    end

    // queue request
    always_comb begin
        o_push.valid     = accept;
        o_push.item.data = i_channel_byte;
        o_push.item.hdr  = starts;
        o_push.item.last = last;
        o_push.item.seq  = r_seq;
        o_push.item.len  = eff_len;
    end

endmodule
`default_nettype wire

FILE: sv/adf_queue.sv
`default_nettype none
module adf_queue (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  adf_pkg::t_push                 i_push,
    input  wire logic                      i_pop,
    output adf_pkg::t_head                 o_head,
    output logic                           o_full,
    output logic [adf_pkg::QCW-1:0]        o_count
);

    adf_pkg::t_item              r_mem [adf_pkg::QDEPTH];
    logic [adf_pkg::QAW-1:0]     r_wptr;
    logic [adf_pkg::QAW-1:0]     r_rptr;
    logic [adf_pkg::QCW-1:0]     r_count;
    logic [adf_pkg::QAW-1:0]     n_wptr;
    logic [adf_pkg::QAW-1:0]     n_rptr;
    logic [adf_pkg::QCW-1:0]     n_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (r_count == adf_pkg::QCW'(adf_pkg::QDEPTH));
    assign o_count = r_count;
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && (r_count != '0);

    // pointer and fill bookkeeping
    always_comb begin
        n_wptr  = do_push ? r_wptr + adf_pkg::QAW'(1) : r_wptr;
        n_rptr  = do_pop ? r_rptr + adf_pkg::QAW'(1) : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + adf_pkg::QCW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - adf_pkg::QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.item;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rptr];

endmodule
`default_nettype wire

FILE: sv/adf_back.sv
`default_nettype none
module adf_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  adf_pkg::t_head                     i_head,
    input  wire logic                          i_stall,
    output logic                               o_pop,
    output logic                               o_valid,
    output logic [adf_pkg::DATA_W-1:0]         o_out_byte,
    output logic                               o_run_last,
    output logic                               o_packet_last
);

    logic [adf_pkg::POS_W-1:0]  r_pos;
    logic [adf_pkg::POS_W-1:0]  n_pos;
    logic                       r_valid;
    logic                       n_valid;
    logic [adf_pkg::DATA_W-1:0] r_byte;
    logic [adf_pkg::DATA_W-1:0] n_byte;
    logic                       r_run_last;
    logic                       n_run_last;
    logic                       r_pkt_last;
    logic                       n_pkt_last;
    logic                       load;
    logic                       in_hdr;

    // output register may take a new byte
    assign load   = !r_valid || !i_stall;
    assign in_hdr = i_head.item.hdr && (r_pos <= adf_pkg::POS_LAST_HDR);

    // header bytes first, then the channel byte
    always_comb begin
        n_pos      = r_pos;
        n_valid    = r_valid && i_stall;
        n_byte     = r_byte;
        n_run_last = r_run_last;
        n_pkt_last = r_pkt_last;
        o_pop      = 1'b0;
        if (load && i_head.valid) begin
            n_valid = 1'b1;
            if (in_hdr) begin
                n_byte     = adf_pkg::hdr_byte(r_pos, i_head.item.seq, i_head.item.len);
                n_run_last = 1'b0;
                n_pkt_last = 1'b0;
                n_pos      = r_pos + adf_pkg::POS_W'(1);
            end else begin
                n_byte     = i_head.item.data;
                n_run_last = 1'b1;
                n_pkt_last = i_head.item.last;
                n_pos      = '0;
                o_pop      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_valid <= n_valid;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_run_last <= n_run_last;
        r_pkt_last <= n_pkt_last;
    end

    assign o_valid       = r_valid;
    assign o_out_byte    = r_byte;
    assign o_run_last    = r_run_last;
    assign o_packet_last = r_pkt_last;

endmodule
`default_nettype wire

FILE: sv/artdmx_packet_framer_core.sv
// channel   direction  handshake            payload
// input     in         i_valid / o_stall    i_channel_byte
// output    out        o_valid / i_stall    o_out_byte, o_run_last, o_packet_last
// config    in         i_cfg_valid / ready  i_cfg_data (frame_length)
//
// a byte that continues a packet leaves as a single output byte; the first byte of a packet
// follows its 18 header bytes, which the back end emits one per cycle unless the output stalls
// a four-entry queue sits between the classifying front end and the back end
// reset is synchronous, active low; frame_length returns to 512
// an output stall holds the result register; the input stalls when the queue is full
`default_nettype none
`include "artdmx_packet_framer_core_defines.svh"
module artdmx_packet_framer_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [adf_pkg::DATA_W-1:0]    i_channel_byte,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [adf_pkg::DATA_W-1:0]         o_out_byte,
    output logic                               o_run_last,
    output logic                               o_packet_last,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [adf_pkg::LEN_W-1:0]     i_cfg_data
);

    logic [adf_pkg::LEN_W-1:0] r_frame_length;
    adf_pkg::t_push            push;
    adf_pkg::t_head            head;
    logic                      full;
    logic                      pop;
    logic [adf_pkg::QCW-1:0]   q_count;

    // frame length register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= adf_pkg::LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_frame_length <= i_cfg_data;
        end
    end

    // classify requests
    adf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_channel_byte (i_channel_byte),
        .i_frame_length (r_frame_length),
        .i_full         (full),
        .o_stall        (o_stall),
        .o_push         (push)
    );

    // decoupling queue
    adf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_count (q_count)
    );

    // header insertion and output register
    adf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_stall       (i_stall),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_packet_last (o_packet_last)
    );

    // checks
    `ADF_ASSERT_IMPL(a_pkt_last_ends_run, o_valid && o_packet_last, o_run_last)
    `ADF_ASSERT_IMPL(a_queue_bound, 1'b1, q_count <= adf_pkg::QCW'(adf_pkg::QDEPTH))
    `ADF_ASSERT_NEXT(a_header_continues, o_valid && !i_stall && !o_run_last, o_valid)

endmodule
`default_nettype wire

FILE: tb/artdmx_packet_framer_core_payload_check.sv
`timescale 1ns / 100ps
module artdmx_packet_framer_core_payload_check (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_stall,
    input  wire logic [adf_pkg::DATA_W-1:0] i_in_byte,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_stall,
    input  wire logic [adf_pkg::DATA_W-1:0] i_out_byte,
    input  wire logic                       i_run_last,
    input  wire logic                       i_packet_last,
    input  wire logic                       i_cfg_valid,
    input  wire logic                       i_cfg_ready,
    input  wire logic [adf_pkg::LEN_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);

    // one byte of the udp payload as it should leave the block
    typedef struct packed {
        logic [adf_pkg::DATA_W-1:0] data;
        logic                       run_last;
        logic                       packet_last;
    } t_payload_byte;

    // protocol id with its zero terminator, first character in the top byte
    localparam logic [63:0] ID_TEXT = {"Art-Net", 8'h00};

    logic [adf_pkg::LEN_W-1:0] frame_len;
    logic [7:0]                seq_num;
    logic [adf_pkg::LEN_W-1:0] chan_pos;
    t_payload_byte             expected_bytes[$];
    int                        errors = 0;

    // zero counts as one, anything past the channel limit as the limit
    function automatic logic [adf_pkg::LEN_W-1:0] clamp_length(
        input logic [adf_pkg::LEN_W-1:0] len
    );
        if (len == '0)
            return adf_pkg::LEN_W'(1);
        if (len > adf_pkg::MAX_CHANNELS)
            return adf_pkg::LEN_W'(adf_pkg::MAX_CHANNELS);
        return len;
    endfunction

    task automatic push_payload_byte(input logic [adf_pkg::DATA_W-1:0] data,
                                     input logic run_last, input logic packet_last);
        t_payload_byte item;
        item.data        = data;
        item.run_last    = run_last;
        item.packet_last = packet_last;
        expected_bytes.push_back(item);
    endtask

    // header ahead of the first channel byte, then the byte itself
    task automatic frame_channel_byte(input logic [adf_pkg::DATA_W-1:0] data);
        logic [adf_pkg::LEN_W-1:0]  len;
        logic [adf_pkg::DATA_W-1:0] hdr [adf_pkg::HDR_BYTES];
        logic                       ends_packet;
        int                         i;
        len = clamp_length(frame_len);
        if (chan_pos == '0) begin
            for (i = 0; i < 8; i++)
                hdr[i] = ID_TEXT[63-8*i -: 8];
            hdr[8]  = adf_pkg::OPCODE_OUTPUT[7:0];
            hdr[9]  = adf_pkg::OPCODE_OUTPUT[15:8];
            hdr[10] = 8'h00;
            hdr[11] = adf_pkg::PROTO_VER_LO;
            hdr[12] = seq_num;
            hdr[13] = 8'h00;
            hdr[14] = 8'h00;
            hdr[15] = 8'h00;
            hdr[16] = {6'b0, len[9:8]};
            hdr[17] = len[7:0];
            for (i = 0; i < adf_pkg::HDR_BYTES; i++)
                push_payload_byte(hdr[i], 1'b0, 1'b0);
            // sequence skips zero once it wraps
            seq_num = seq_num + 8'd1;
            if (seq_num == 8'd0)
                seq_num = 8'd1;
        end
        ends_packet = ({1'b0, chan_pos} + 11'd1) >= {1'b0, len};
        push_payload_byte(data, 1'b1, ends_packet);
        chan_pos = ends_packet ? '0 : chan_pos + 1'b1;
    endtask

    // compare one accepted result with the oldest expectation
    task automatic check_payload_byte();
        t_payload_byte want;
        if (expected_bytes.size() == 0) begin
            errors++;
            $display("%0t: result with none expected, actual byte %02h run_last %b",
                     $time, i_out_byte, i_run_last);
            $display("%0t: unexpected result packet_last %b", $time, i_packet_last);
        end else begin
            want = expected_bytes.pop_front();
            if (i_out_byte !== want.data) begin
                errors++;
                $display("%0t: out_byte expected %02h actual %02h", $time, want.data, i_out_byte);
            end
            if (i_run_last !== want.run_last) begin
                errors++;
                $display("%0t: run_last expected %b actual %b", $time, want.run_last, i_run_last);
            end
            if (i_packet_last !== want.packet_last) begin
                errors++;
                $display("%0t: packet_last expected %b actual %b", $time, want.packet_last,
                         i_packet_last);
            end
        end
    endtask

    // follow config writes, input requests and output requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_len = adf_pkg::LEN_RESET;
            seq_num   = '0;
            chan_pos  = '0;
            expected_bytes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                frame_len = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                frame_channel_byte(i_in_byte);
            if (i_out_valid && !i_out_stall)
                check_payload_byte();
        end
        o_fail_count <= errors;
        o_pending    <= expected_bytes.size();
    end

endmodule

FILE: tb/artdmx_packet_framer_core_tb.sv
`timescale 1ns / 100ps
module artdmx_packet_framer_core_tb;

    localparam int IDLE_PCT    = 36;
    localparam int QUIET_LIMIT = 2000;
    localparam int WRAP_ITEMS  = 256;
    localparam int MIXED_ITEMS = 100;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_valid        = 1'b0;
    logic [adf_pkg::DATA_W-1:0] i_channel_byte = '0;
    logic                       i_stall        = 1'b0;
    logic                       i_cfg_valid    = 1'b0;
    logic [adf_pkg::LEN_W-1:0]  i_cfg_data     = '0;
    logic                       o_stall;
    logic                       o_valid;
    logic [adf_pkg::DATA_W-1:0] o_out_byte;
    logic                       o_run_last;
    logic                       o_packet_last;
    logic                       o_cfg_ready;

    bit steady_run   = 1'b0;
    int quiet_cycles = 0;
    int fail_count;
    int pending;

    artdmx_packet_framer_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_channel_byte (i_channel_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last),
        .o_packet_last  (o_packet_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    artdmx_packet_framer_core_payload_check u_payload_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_in_byte     (i_channel_byte),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_out_byte    (o_out_byte),
        .i_run_last    (o_run_last),
        .i_packet_last (o_packet_last),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #1 i_clk = ~i_clk;

    // random back pressure on the output
    always @(posedge i_clk) begin
        i_stall <= !steady_run && ($urandom_range(99) < IDLE_PCT);
    end

    // give up when no request moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("artdmx_packet_framer_core_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one channel byte request, valid is left high on return
    task automatic send_channel_byte(input logic [adf_pkg::DATA_W-1:0] value);
        while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_channel_byte <= value;
        do @(posedge i_clk); while (o_stall);
    endtask

    // hold the input until every expected byte has left
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_frame_length(input logic [adf_pkg::LEN_W-1:0] len);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int                        sent;
        int                        phase_items;
        int                        i;
        logic [adf_pkg::LEN_W-1:0] len;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset length, packet left open
        send_channel_byte(8'h00);
        send_channel_byte(8'hff);
        send_channel_byte(8'h55);
        // shorter length mid packet ends it on the next byte
        write_frame_length(10'd2);
        send_channel_byte(8'haa);
        send_channel_byte(8'h01);
        send_channel_byte(8'h80);
        // zero length acts as one
        write_frame_length(10'd0);
        send_channel_byte(8'h7f);
        send_channel_byte(8'hfe);
        // oversize lengths clamp to the channel limit
        write_frame_length(10'h3ff);
        send_channel_byte(8'h33);
        send_channel_byte(8'hcc);
        send_channel_byte(8'h0f);
        write_frame_length(10'd513);
        send_channel_byte(8'hf0);
        send_channel_byte(8'h5a);
        write_frame_length(10'd3);
        send_channel_byte(8'ha5);
        write_frame_length(10'd1);
        send_channel_byte(8'h96);

        // one byte packets, enough to wrap the sequence byte
        for (i = 0; i < WRAP_ITEMS; i++) begin
            steady_run = (i >= 40 && i < 140);
            send_channel_byte(8'($urandom_range(255)));
        end
        steady_run = 1'b0;

        // mixed lengths, changed between runs of random size
        sent = 0;
        while (sent < MIXED_ITEMS) begin
            case ($urandom_range(9))
                0, 1, 2, 3: len = adf_pkg::LEN_W'($urandom_range(1, 6));
                4:          len = adf_pkg::LEN_W'($urandom_range(7, 40));
                5:          len = 10'd1;
                6:          len = adf_pkg::LEN_W'($urandom_range(41, 1023));
                7:          len = 10'd512;
                8:          len = 10'd0;
                default:    len = 10'h3ff;
            endcase
            write_frame_length(len);
            phase_items = $urandom_range(1, 25);
            for (i = 0; i < phase_items; i++) begin
                if ($urandom_range(49) == 0)
                    wait_drained();
                send_channel_byte(8'($urandom_range(255)));
            end
            sent += phase_items;
        end

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("artdmx_packet_framer_core_tb passed");
        else
            $display("artdmx_packet_framer_core_tb failed");
        $finish;
    end

endmodule
